[src/frobnicated_word_sorter_macros.svh]
// Assertion macros used by the word sorter top level.
`ifndef FROBNICATED_WORD_SORTER_MACROS_SVH
`define FROBNICATED_WORD_SORTER_MACROS_SVH
`ifndef ASSERT_OFF
// Condition holds at every clock edge outside reset.
`define FWS_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
	else $error("assertion failed");
// Antecedent at one edge implies the consequent at the next edge.
`define FWS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define FWS_ASSERT_ALWAYS(lbl, cond)
`define FWS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/fws_pkg.sv]
// Package with constants and helpers of the word sorter.
package fws_pkg;
	localparam int MAX_BYTES_DEF = 4096;
	localparam int MAX_WORDS_DEF = 512;
	localparam logic [7:0] SPACE_BYTE = 8'h20;
	localparam logic [7:0] DECODE_KEY = 8'd42;
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_FINISH = 2'd1;
	localparam logic [1:0] OP_FETCH  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Decode a stored byte into the signed value used for ordering.
	function automatic logic signed [7:0] decode_byte(input logic [7:0] b);
		return $signed(b ^ DECODE_KEY);
	endfunction
endpackage

[src/fws_byte_mem.sv]
// Byte store: one write port and two registered read ports.
module fws_byte_mem import fws_pkg::*; #(
	parameter int MAX_BYTES = MAX_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(MAX_BYTES)-1:0] waddr,
	input  logic [7:0]                   wdata,
	input  logic [$clog2(MAX_BYTES)-1:0] raddr_a,
	input  logic [$clog2(MAX_BYTES)-1:0] raddr_b,
	output logic [7:0]                   rdata_a,
	output logic [7:0]                   rdata_b
);
	logic [7:0] mem [MAX_BYTES];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Two registered read ports: data appears in the cycle after the address.
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

[src/fws_word_mem.sv]
// Word table: start addresses of words, one write and one registered read port.
module fws_word_mem import fws_pkg::*; #(
	parameter int MAX_BYTES = MAX_BYTES_DEF,
	parameter int MAX_WORDS = MAX_WORDS_DEF
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(MAX_WORDS)-1:0] waddr,
	input  logic [$clog2(MAX_BYTES)-1:0] wdata,
	input  logic [$clog2(MAX_WORDS)-1:0] raddr,
	output logic [$clog2(MAX_BYTES)-1:0] rdata
);
	logic [$clog2(MAX_BYTES)-1:0] mem [MAX_WORDS];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port: data appears in the cycle after the address.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

[src/frobnicated_word_sorter.sv]
// Top level of the word sorter: control sequencer around the two memories.
// Usage: each input transaction carries an operation (load byte, finish and
// sort, fetch) and a data byte; each one yields exactly one response
// transaction with out_byte, out_valid, out_done and overflow.
// Load and ignored operations load the response register as they are taken. A fetch
// reads its byte in ST_FETCH_BY and answers from ST_RESULT; a fetched space
// passes ST_SKIP_RD, ST_SKIP_WO and ST_SKIP_BY to find the start of the
// next word, again for every lone-space word skipped, or goes to ST_RESULT
// when no word is left. Finish runs an insertion sort over the word table:
// each compare step passes ST_SORT_JP, ST_SORT_PRV and ST_CMP, staying in
// ST_CMP while the byte pairs read from the byte store match.
// The block works on one transaction at a time; in_ready is high only when
// the sequencer is idle and the response register is free or being drained.
// A stalled receiver holds the response in its register, and new input is
// held off for as long as that response waits.
// Reset clears the fill, word and fetch counters and control flags and goes
// back to loading; memories are not cleared, as only written entries are read.
`include "frobnicated_word_sorter_macros.svh"
module frobnicated_word_sorter import fws_pkg::*; #(
	parameter int MAX_BYTES = MAX_BYTES_DEF,
	parameter int MAX_WORDS = MAX_WORDS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [7:0] data_byte,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic [7:0] out_byte,
	output logic       out_valid,
	output logic       out_done,
	output logic       overflow
);
	localparam int AW  = $clog2(MAX_BYTES);
	localparam int FPW = $clog2(MAX_BYTES + 1);
	localparam int WAW = $clog2(MAX_WORDS);
	localparam int WCW = $clog2(MAX_WORDS + 1);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_SORT_I   = 4'd1;
	localparam logic [3:0] ST_SORT_KEY = 4'd2;
	localparam logic [3:0] ST_SORT_JP  = 4'd3;
	localparam logic [3:0] ST_SORT_PRV = 4'd4;
	localparam logic [3:0] ST_CMP      = 4'd5;
	localparam logic [3:0] ST_SKIP_RD  = 4'd6;
	localparam logic [3:0] ST_SKIP_WO  = 4'd7;
	localparam logic [3:0] ST_SKIP_BY  = 4'd8;
	localparam logic [3:0] ST_FETCH_BY = 4'd9;
	localparam logic [3:0] ST_RESULT   = 4'd10;

	logic [3:0]     state_q, state_d;
	logic [FPW-1:0] fp_q, fp_d, open_q, open_d;
	logic [WCW-1:0] wc_q, wc_d, rw_q, rw_d, i_q, i_d, j_q, j_d;
	logic [AW-1:0]  rp_q, rp_d, key_q, key_d, prev_q, prev_d;
	logic [AW-1:0]  pa_q, pa_d, pb_q, pb_d;
	logic           phase_q, phase_d, drop_q, drop_d;
	logic [7:0]     pend_byte_q, pend_byte_d;
	logic           pend_valid_q, pend_valid_d;
	logic           rsp_valid_q, rsp_valid_d;
	logic [7:0]     ob_q, ob_d;
	logic           ov_q, ov_d, od_q, od_d, of_q, of_d;

	logic           b_we;
	logic [AW-1:0]  b_waddr, b_raddr_a, b_raddr_b;
	logic [7:0]     b_wdata, b_rdata_a, b_rdata_b;
	logic           w_we;
	logic [WAW-1:0] w_waddr, w_raddr;
	logic [AW-1:0]  w_wdata, w_rdata;

	logic           out_free, accept, exhausted, is_space, room;
	logic           ea, eb, greater, settled;
	logic [WCW-1:0] jm1;

	fws_byte_mem #(.MAX_BYTES(MAX_BYTES)) u_byte_mem (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.raddr_a(b_raddr_a), .raddr_b(b_raddr_b),
		.rdata_a(b_rdata_a), .rdata_b(b_rdata_b)
	);

	fws_word_mem #(.MAX_BYTES(MAX_BYTES), .MAX_WORDS(MAX_WORDS)) u_word_mem (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr), .rdata(w_rdata)
	);

	// Handshake and common conditions.
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign exhausted = (rw_q >= wc_q);
	assign is_space  = (data_byte == SPACE_BYTE);
	assign room      = (wc_q < WCW'(MAX_WORDS)) &&
		(is_space ? (fp_q < FPW'(MAX_BYTES)) : (fp_q < FPW'(MAX_BYTES - 1)));
	assign jm1       = j_q - 1'b1;

	// Byte compare of two words during the sort.
	assign ea      = (b_rdata_a == SPACE_BYTE);
	assign eb      = (b_rdata_b == SPACE_BYTE);
	assign greater = !ea && (eb || (decode_byte(b_rdata_a) > decode_byte(b_rdata_b)));
	assign settled = ea || (decode_byte(b_rdata_a) < decode_byte(b_rdata_b));

	// Sequencer next state and memory control.
	always_comb begin
		state_d      = state_q;
		fp_d         = fp_q;
		open_d       = open_q;
		wc_d         = wc_q;
		rw_d         = rw_q;
		i_d          = i_q;
		j_d          = j_q;
		rp_d         = rp_q;
		key_d        = key_q;
		prev_d       = prev_q;
		pa_d         = pa_q;
		pb_d         = pb_q;
		phase_d      = phase_q;
		drop_d       = drop_q;
		pend_byte_d  = pend_byte_q;
		pend_valid_d = pend_valid_q;
		rsp_valid_d  = rsp_valid_q && !rsp_ready;
		ob_d         = ob_q;
		ov_d         = ov_q;
		od_d         = od_q;
		of_d         = of_q;
		b_we         = 1'b0;
		b_waddr      = fp_q[AW-1:0];
		b_wdata      = data_byte;
		b_raddr_a    = rp_q;
		b_raddr_b    = key_q;
		w_we         = 1'b0;
		w_waddr      = wc_q[WAW-1:0];
		w_wdata      = open_q[AW-1:0];
		w_raddr      = i_q[WAW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rsp_valid_d = 1'b1;
					ob_d        = 8'd0;
					ov_d        = 1'b0;
					od_d        = phase_q && exhausted;
					of_d        = drop_q;
					case (operation)
						OP_LOAD: begin
							if (!phase_q) begin
								if (room) begin
									b_we = 1'b1;
									fp_d = fp_q + 1'b1;
									if (is_space) begin
										w_we   = 1'b1;
										wc_d   = wc_q + 1'b1;
										open_d = fp_q + 1'b1;
									end
								end else begin
									drop_d = 1'b1;
									of_d   = 1'b1;
								end
							end
						end
						OP_FINISH: begin
							if (!phase_q) begin
								rsp_valid_d = rsp_valid_q && !rsp_ready;
								if ((fp_q > open_q) && (fp_q < FPW'(MAX_BYTES)) &&
									(wc_q < WCW'(MAX_WORDS))) begin
									b_we    = 1'b1;
									b_wdata = SPACE_BYTE;
									fp_d    = fp_q + 1'b1;
									w_we    = 1'b1;
									wc_d    = wc_q + 1'b1;
									open_d  = fp_q + 1'b1;
								end
								phase_d      = 1'b1;
								i_d          = WCW'(1);
								rw_d         = '0;
								rp_d         = '0;
								pend_byte_d  = 8'd0;
								pend_valid_d = 1'b0;
								state_d      = ST_SORT_I;
							end
						end
						OP_FETCH: begin
							if (phase_q && !exhausted) begin
								rsp_valid_d = rsp_valid_q && !rsp_ready;
								b_raddr_a   = rp_q;
								state_d     = ST_FETCH_BY;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_SORT_I: begin
				if (i_q >= wc_q) begin
					state_d = ST_SKIP_RD;
				end else begin
					w_raddr = i_q[WAW-1:0];
					state_d = ST_SORT_KEY;
				end
			end
			ST_SORT_KEY: begin
				key_d   = w_rdata;
				j_d     = i_q;
				state_d = ST_SORT_JP;
			end
			ST_SORT_JP: begin
				if (j_q == '0) begin
					w_we    = 1'b1;
					w_waddr = j_q[WAW-1:0];
					w_wdata = key_q;
					i_d     = i_q + 1'b1;
					state_d = ST_SORT_I;
				end else begin
					w_raddr = jm1[WAW-1:0];
					state_d = ST_SORT_PRV;
				end
			end
			ST_SORT_PRV: begin
				prev_d    = w_rdata;
				b_raddr_a = w_rdata;
				b_raddr_b = key_q;
				pa_d      = w_rdata + 1'b1;
				pb_d      = key_q + 1'b1;
				state_d   = ST_CMP;
			end
			ST_CMP: begin
				if (greater) begin
					w_we    = 1'b1;
					w_waddr = j_q[WAW-1:0];
					w_wdata = prev_q;
					j_d     = jm1;
					state_d = ST_SORT_JP;
				end else if (settled) begin
					w_we    = 1'b1;
					w_waddr = j_q[WAW-1:0];
					w_wdata = key_q;
					i_d     = i_q + 1'b1;
					state_d = ST_SORT_I;
				end else begin
					b_raddr_a = pa_q;
					b_raddr_b = pb_q;
					pa_d      = pa_q + 1'b1;
					pb_d      = pb_q + 1'b1;
				end
			end
			ST_SKIP_RD: begin
				if (exhausted) begin
					state_d = ST_RESULT;
				end else begin
					w_raddr = rw_q[WAW-1:0];
					state_d = ST_SKIP_WO;
				end
			end
			ST_SKIP_WO: begin
				rp_d      = w_rdata;
				b_raddr_a = w_rdata;
				state_d   = ST_SKIP_BY;
			end
			ST_SKIP_BY: begin
				if (b_rdata_a == SPACE_BYTE) begin
					rw_d    = rw_q + 1'b1;
					state_d = ST_SKIP_RD;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_FETCH_BY: begin
				pend_byte_d  = b_rdata_a;
				pend_valid_d = 1'b1;
				rp_d         = rp_q + 1'b1;
				if (b_rdata_a == SPACE_BYTE) begin
					rw_d    = rw_q + 1'b1;
					state_d = ST_SKIP_RD;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					rsp_valid_d = 1'b1;
					ob_d        = pend_byte_q;
					ov_d        = pend_valid_q;
					od_d        = phase_q && exhausted;
					of_d        = drop_q;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fp_q         <= '0;
			open_q       <= '0;
			wc_q         <= '0;
			rw_q         <= '0;
			rp_q         <= '0;
			phase_q      <= 1'b0;
			drop_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			fp_q         <= fp_d;
			open_q       <= open_d;
			wc_q         <= wc_d;
			rw_q         <= rw_d;
			rp_q         <= rp_d;
			phase_q      <= phase_d;
			drop_q       <= drop_d;
			rsp_valid_q  <= rsp_valid_d;
			pend_valid_q <= pend_valid_d;
		end
	end

	// Working and response payload registers.
	always_ff @(posedge clk) begin
		i_q         <= i_d;
		j_q         <= j_d;
		key_q       <= key_d;
		prev_q      <= prev_d;
		pa_q        <= pa_d;
		pb_q        <= pb_d;
		pend_byte_q <= pend_byte_d;
		ob_q        <= ob_d;
		ov_q        <= ov_d;
		od_q        <= od_d;
		of_q        <= of_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign out_byte  = ob_q;
	assign out_valid = ov_q;
	assign out_done  = od_q;
	assign overflow  = of_q;

	// Checks on the sequencer and its counters.
	`FWS_ASSERT_ALWAYS(a_wc_bound, wc_q <= WCW'(MAX_WORDS))
	`FWS_ASSERT_ALWAYS(a_fp_bound, fp_q <= FPW'(MAX_BYTES))
	`FWS_ASSERT_NEXT(a_phase_sticky, phase_q, phase_q)
	`FWS_ASSERT_ALWAYS(a_busy_no_ready, (state_q == ST_IDLE) || !in_ready)
endmodule
